// ===== rtl/core/hsa_pkg.sv =====
// Shared constants and types of the HSP saturation adjust block.
package hsa_pkg;

    localparam int ChanW   = 8;
    localparam int WeightW = 16;
    localparam int GainW   = 16;
    localparam int SumW    = 34;
    localparam int RootW   = 17;
    localparam int RemW    = 19;
    localparam int NumCells = 17;
    localparam int ProdW   = 36;
    localparam int DiffW   = 18;
    localparam int ValW    = 38;

    localparam logic [ChanW-1:0] PixMax = 8'd255;

    localparam logic [GainW-1:0]   GainReset  = 16'd4096;
    localparam logic [WeightW-1:0] RedReset   = 16'd19595;
    localparam logic [WeightW-1:0] GreenReset = 16'd38470;
    localparam logic [WeightW-1:0] BlueReset  = 16'd7471;

    typedef enum logic [1:0] {
        REG_GAIN  = 2'd0,
        REG_RED   = 2'd1,
        REG_GREEN = 2'd2,
        REG_BLUE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
    } t_pixel;

    // Payload that travels along the row of square root cells.
    typedef struct packed {
        logic             vld;
        logic             bypass;
        t_pixel           pix;
        logic [SumW-1:0]  rad;
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
    } t_cell;

endpackage

// ===== rtl/core/hsp_saturation_adjust.sv =====
// Top level of the HSP saturation adjust block: registers, sum stage, root row, adjust stages.
// Pipeline stages from input transfer to output: 2 sum, 17 root cells, 3 adjust/output.
// Throughput: one pixel per cycle; the pipeline advances whenever the output is free.
// The root is found by a row of 17 cells, each settling one bit of the 17-bit root.
// Reset is synchronous, active low; it empties the pipeline and loads the register defaults.
module hsp_saturation_adjust
    import hsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic        m_axis_tuser    // was_adjusted
);

    logic [GainW-1:0]   r_gain;
    logic [WeightW-1:0] r_wr, r_wg, r_wb;
    logic               w_wr;
    logic               w_en;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GainReset;
            r_wr   <= RedReset;
            r_wg   <= GreenReset;
            r_wb   <= BlueReset;
        end else if (w_wr) begin
            case (w_idx)
                REG_GAIN:  r_gain <= pwdata[GainW-1:0];
                REG_RED:   r_wr   <= pwdata[WeightW-1:0];
                REG_GREEN: r_wg   <= pwdata[WeightW-1:0];
                REG_BLUE:  r_wb   <= pwdata[WeightW-1:0];
                default:   r_gain <= r_gain;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GAIN:  prdata = {16'h0, r_gain};
            REG_RED:   prdata = {16'h0, r_wr};
            REG_GREEN: prdata = {16'h0, r_wg};
            REG_BLUE:  prdata = {16'h0, r_wb};
            default:   prdata = '0;
        endcase
    end

    // The whole pipeline stalls together only when the output holds an untaken transfer.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    t_pixel w_pix;
    assign w_pix.red   = s_axis_tdata[7:0];
    assign w_pix.green = s_axis_tdata[15:8];
    assign w_pix.blue  = s_axis_tdata[23:16];
    assign w_pix.alpha = s_axis_tdata[31:24];

    // Stage 1: squares; stage 2: weighted products summed.
    logic           r_v1, r_v2;
    t_pixel         r_p1, r_p2;
    logic           r_b1, r_b2;
    logic [15:0]    r_sq_r, r_sq_g, r_sq_b;
    logic [31:0]    w_pr, w_pg, w_pb;
    logic [SumW-1:0] r_sum;

    assign w_pr = r_sq_r * r_wr;
    assign w_pg = r_sq_g * r_wg;
    assign w_pb = r_sq_b * r_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1   <= w_pix;
            r_b1   <= (w_pix.alpha == PixMax)
                   && ((w_pix.red == 8'd0 && w_pix.green == 8'd0 && w_pix.blue == 8'd0)
                   || (w_pix.red == PixMax && w_pix.green == PixMax
                       && w_pix.blue == PixMax));
            r_sq_r <= w_pix.red * w_pix.red;
            r_sq_g <= w_pix.green * w_pix.green;
            r_sq_b <= w_pix.blue * w_pix.blue;
            r_p2   <= r_p1;
            r_b2   <= r_b1;
            r_sum  <= SumW'(w_pr) + SumW'(w_pg) + SumW'(w_pb);
        end
    end

    t_cell w_chain [NumCells+1];

    assign w_chain[0].vld    = r_v2;
    assign w_chain[0].bypass = r_b2;
    assign w_chain[0].pix    = r_p2;
    assign w_chain[0].rad    = r_sum;
    assign w_chain[0].rem    = '0;
    assign w_chain[0].root   = '0;

    for (genvar k = 0; k < NumCells; k++) begin : g_cell
        hsa_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[k]),
            .o_cell  (w_chain[k+1])
        );
    end

    t_cell w_last;
    assign w_last = w_chain[NumCells];

    logic [ChanW-1:0] w_nr, w_ng, w_nb;
    logic             w_okr, w_okg, w_okb;

    hsa_chan_adjust u_adj_r (.i_clk(i_clk), .i_en(w_en), .i_root(w_last.root),
        .i_chan(w_last.pix.red), .i_gain(r_gain), .o_chan(w_nr), .o_ok(w_okr));
    hsa_chan_adjust u_adj_g (.i_clk(i_clk), .i_en(w_en), .i_root(w_last.root),
        .i_chan(w_last.pix.green), .i_gain(r_gain), .o_chan(w_ng), .o_ok(w_okg));
    hsa_chan_adjust u_adj_b (.i_clk(i_clk), .i_en(w_en), .i_root(w_last.root),
        .i_chan(w_last.pix.blue), .i_gain(r_gain), .o_chan(w_nb), .o_ok(w_okb));

    logic   r_va, r_vb;
    t_pixel r_pa, r_pb;
    logic   r_ba, r_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (w_en) begin
            r_va <= w_last.vld;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa <= w_last.pix;
            r_ba <= w_last.bypass;
            r_pb <= r_pa;
            r_bb <= r_ba;
        end
    end

    logic        r_ov;
    logic [31:0] r_od;
    logic        r_ou;
    logic        w_adj;

    assign w_adj = !r_bb && w_okr && w_okg && w_okb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ou <= w_adj;
            r_od <= w_adj ? {PixMax, w_nb, w_ng, w_nr}
                          : {r_pb.alpha, r_pb.blue, r_pb.green, r_pb.red};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ou;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:24] == PixMax)
        else $error("adjusted pixel without full alpha");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

// ===== rtl/core/hsa_sqrt_cell.sv =====
// One cell of the square root row: resolves one root bit and holds it for the next cell.
module hsa_sqrt_cell
    import hsa_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_cell  i_cell,
    output t_cell  o_cell
);

    t_cell r_cell;
    t_cell n_cell;
    logic [RemW-1:0] w_rem;
    logic [RemW-1:0] w_trial;

    always_comb begin
        n_cell = i_cell;
        w_rem   = {i_cell.rem[RemW-3:0], i_cell.rad[SumW-1:SumW-2]};
        w_trial = {i_cell.root, 2'b01};
        n_cell.rad = {i_cell.rad[SumW-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_cell.rem  = w_rem - w_trial;
            n_cell.root = {i_cell.root[RootW-2:0], 1'b1};
        end else begin
            n_cell.rem  = w_rem;
            n_cell.root = {i_cell.root[RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== rtl/core/hsa_chan_adjust.sv =====
// Two-stage channel adjustment: gain product, then rounding and range check.
module hsa_chan_adjust
    import hsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [RootW-1:0]   i_root,
    input  logic [ChanW-1:0]   i_chan,
    input  logic [GainW-1:0]   i_gain,
    output logic [ChanW-1:0]   o_chan,
    output logic               o_ok
);

    logic signed [DiffW-1:0] w_diff;
    logic signed [ProdW-1:0] r_prod;
    logic        [RootW-1:0] r_root;
    logic signed [ValW-1:0]  w_val;
    logic        [ValW-1:0]  w_mag;
    logic        [ValW-1:0]  w_rnd;
    logic        [ChanW-1:0] r_chan;
    logic                    r_ok;

    assign w_diff = $signed({2'b00, i_chan, 8'h00}) - $signed({1'b0, i_root});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= ProdW'(w_diff * $signed({1'b0, i_gain}));
            r_root <= i_root;
        end
    end

    assign w_val = $signed({{(ValW-RootW-12){1'b0}}, r_root, 12'h000})
                 + ValW'(r_prod);
    assign w_mag = w_val[ValW-1] ? ValW'(-w_val) : ValW'(w_val);
    assign w_rnd = (w_mag + (ValW'(1) << 19)) >> 20;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= w_rnd[ChanW-1:0];
            r_ok   <= (w_rnd[ValW-1:ChanW] == '0)
                   && (!w_val[ValW-1] || w_rnd == '0);
        end
    end

    assign o_chan = r_chan;
    assign o_ok   = r_ok;

endmodule
